### src/jfp_pkg.sv
// Shared constants, codes and types of the joystick frame parser.
`timescale 1ns / 1ps

package jfp_pkg;

	// Default geometry
	localparam int FRAME_LENGTH_DEF = 25;
	localparam int VALUE_WIDTH_DEF  = 16;

	// Fixed field widths
	localparam int BTN_W      = 8;
	localparam int AXIS_W     = 16;
	localparam int DB_W       = 15;
	localparam int CNT_W      = 3;
	localparam int NUM_VALUES = 5;
	localparam int NUM_AXES   = 4;

	localparam logic [DB_W-1:0]  DEADBAND_RESET = DB_W'(20);
	localparam logic [CNT_W-1:0] VALUES_FULL    = CNT_W'(NUM_VALUES);

	// Character codes
	localparam logic [7:0] CH_OPEN  = 8'h3C; // '<'
	localparam logic [7:0] CH_NL    = 8'h0A; // newline
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Frame status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_MISALIGNED = 2'd1,
		ST_SHORT      = 2'd2
	} status_t;

	// Scanner phase
	typedef enum logic [1:0] {
		PH_BRACKET,
		PH_BEFORE,
		PH_NUMBER
	} scan_phase_t;

endpackage

### src/jfp_ifs.sv
// Channel interfaces of the joystick frame parser: byte input, result output, configuration.
`timescale 1ns / 1ps

interface jfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface jfp_result_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic [jfp_pkg::BTN_W-1:0]           buttons;
	logic signed [jfp_pkg::AXIS_W-1:0]   left_x;
	logic signed [jfp_pkg::AXIS_W-1:0]   left_y;
	logic signed [jfp_pkg::AXIS_W-1:0]   right_x;
	logic signed [jfp_pkg::AXIS_W-1:0]   right_y;

	modport source (output valid, output status, output buttons, output left_x,
		output left_y, output right_x, output right_y, input ready);
	modport sink   (input valid, input status, input buttons, input left_x,
		input left_y, input right_x, input right_y, output ready);
endinterface

interface jfp_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [jfp_pkg::DB_W-1:0] deadband;

	modport source (output valid, output deadband, input ready);
	modport sink   (input valid, input deadband, output ready);
endinterface

### src/joystick_frame_parser.sv
// Top level of the joystick frame parser: byte scanner, frame check and held result.
//
//  channel | dir | payload                                          | handshake
//  rx      | in  | rx_byte[7:0]                                     | valid/ready
//  res     | out | status, buttons, left_x, left_y, right_x, right_y | valid/ready
//  cfg     | in  | deadband[14:0]                                   | valid/ready
//
// One byte is taken every cycle unless input stalls; a byte is scanned in the input
// register, and the last byte of a frame loads its result into the result register.
// One result leaves per FRAME_LENGTH bytes.
// Reset clears the frame count, the scanner and the held values; deadband returns to 20.
// Input stalls only while the last byte of a frame waits for a full result register.
`timescale 1ns / 1ps

module joystick_frame_parser #(
	parameter int FRAME_LENGTH = jfp_pkg::FRAME_LENGTH_DEF,
	parameter int VALUE_WIDTH  = jfp_pkg::VALUE_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	jfp_byte_if.sink     rx,
	jfp_result_if.source res,
	jfp_cfg_if.sink      cfg
);

	localparam int POS_W = $clog2(FRAME_LENGTH);
	localparam int ACC_W = VALUE_WIDTH;
	localparam int MUL_W = VALUE_WIDTH + 4;
	localparam int CMP_W = ((VALUE_WIDTH > jfp_pkg::AXIS_W) ? VALUE_WIDTH : jfp_pkg::AXIS_W) + 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);
	localparam logic [ACC_W-1:0] MAG_LIM  = ACC_W'(1) << (VALUE_WIDTH - 1);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Scanner state
	logic [POS_W-1:0]               pos_q;
	logic                           start_ok_q;
	jfp_pkg::scan_phase_t           phase_q;
	logic [jfp_pkg::CNT_W-1:0]      count_q;
	logic [ACC_W-1:0]               acc_q;
	logic                           neg_q;
	logic                           seen_q;
	logic                           stopped_q;
	logic signed [VALUE_WIDTH-1:0]  pend_q [jfp_pkg::NUM_VALUES];

	// Result and configuration registers
	logic                               out_valid_q;
	jfp_pkg::status_t                   status_q;
	logic [jfp_pkg::BTN_W-1:0]          buttons_q;
	logic signed [jfp_pkg::AXIS_W-1:0]  axes_q [jfp_pkg::NUM_AXES];
	logic [jfp_pkg::DB_W-1:0]           deadband_q;

	// Next-state signals
	logic                           last;
	logic                           advance;
	logic                           is_digit;
	logic                           is_space;
	logic [MUL_W-1:0]               prod;
	logic signed [VALUE_WIDTH-1:0]  fin;
	logic                           start_ok_nxt;
	jfp_pkg::scan_phase_t           phase_nxt;
	logic [jfp_pkg::CNT_W-1:0]      count_nxt;
	logic [ACC_W-1:0]               acc_nxt;
	logic                           neg_nxt;
	logic                           seen_nxt;
	logic                           stopped_nxt;
	logic                           wr_en;
	logic signed [VALUE_WIDTH-1:0]  pend_view [jfp_pkg::NUM_VALUES];
	logic signed [CMP_W-1:0]        db_ext;
	logic signed [CMP_W-1:0]        v_ext [jfp_pkg::NUM_AXES];
	logic signed [jfp_pkg::AXIS_W-1:0] axes_nxt [jfp_pkg::NUM_AXES];
	jfp_pkg::status_t               status_nxt;

	// Flow control
	assign last    = (pos_q == LAST_POS);
	assign advance = valid_s1 && (!last || !out_valid_q || res.ready);
	assign rx.ready  = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Close the current number with saturation
	always_comb begin
		if (neg_q) begin
			fin = $signed(ACC_W'(0) - acc_q);
		end else if (acc_q == MAG_LIM) begin
			fin = $signed(MAG_LIM - ACC_W'(1));
		end else begin
			fin = $signed(acc_q);
		end
	end

	// Scan one byte
	always_comb begin
		is_digit = (byte_s1 >= jfp_pkg::CH_ZERO) && (byte_s1 <= jfp_pkg::CH_NINE);
		is_space = (byte_s1 == jfp_pkg::CH_SPACE) ||
			((byte_s1 >= jfp_pkg::CH_TAB) && (byte_s1 <= jfp_pkg::CH_CR));
		prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + MUL_W'(byte_s1[3:0]);

		start_ok_nxt = (pos_q == '0) ? (byte_s1 == jfp_pkg::CH_OPEN) : start_ok_q;
		phase_nxt    = phase_q;
		count_nxt    = count_q;
		acc_nxt      = acc_q;
		neg_nxt      = neg_q;
		seen_nxt     = seen_q;
		stopped_nxt  = stopped_q;
		wr_en        = 1'b0;

		if (!stopped_q) begin
			unique case (phase_q)
				jfp_pkg::PH_BRACKET: begin
					if (byte_s1 == jfp_pkg::CH_OPEN) begin
						phase_nxt = jfp_pkg::PH_BEFORE;
						acc_nxt   = '0;
						neg_nxt   = 1'b0;
						seen_nxt  = 1'b0;
					end else begin
						stopped_nxt = 1'b1;
					end
				end
				jfp_pkg::PH_BEFORE: begin
					if (is_space) begin
						phase_nxt = jfp_pkg::PH_BEFORE;
					end else if (byte_s1 == jfp_pkg::CH_PLUS || byte_s1 == jfp_pkg::CH_MINUS) begin
						neg_nxt   = (byte_s1 == jfp_pkg::CH_MINUS);
						phase_nxt = jfp_pkg::PH_NUMBER;
					end else if (is_digit) begin
						acc_nxt   = ACC_W'(byte_s1[3:0]);
						seen_nxt  = 1'b1;
						phase_nxt = jfp_pkg::PH_NUMBER;
					end else begin
						stopped_nxt = 1'b1;
					end
				end
				jfp_pkg::PH_NUMBER: begin
					if (is_digit) begin
						acc_nxt  = (prod > MUL_W'(MAG_LIM)) ? MAG_LIM : prod[ACC_W-1:0];
						seen_nxt = 1'b1;
					end else if (!seen_q) begin
						stopped_nxt = 1'b1;
					end else begin
						wr_en     = (count_q < jfp_pkg::VALUES_FULL);
						count_nxt = count_q + 1'b1;
						if (count_nxt >= jfp_pkg::VALUES_FULL || byte_s1 != jfp_pkg::CH_COMMA) begin
							stopped_nxt = 1'b1;
						end else begin
							phase_nxt = jfp_pkg::PH_BEFORE;
							acc_nxt   = '0;
							neg_nxt   = 1'b0;
							seen_nxt  = 1'b0;
						end
					end
				end
				default: begin
					stopped_nxt = 1'b1;
				end
			endcase
		end
	end

	// Frame result: merge the number closed by this byte, then apply deadband
	always_comb begin
		for (int i = 0; i < jfp_pkg::NUM_VALUES; i++) begin
			pend_view[i] = (wr_en && count_q == jfp_pkg::CNT_W'(i)) ? fin : pend_q[i];
		end
		db_ext = $signed({{(CMP_W - jfp_pkg::DB_W){1'b0}}, deadband_q});
		for (int i = 0; i < jfp_pkg::NUM_AXES; i++) begin
			v_ext[i] = $signed({{(CMP_W - VALUE_WIDTH){pend_view[i+1][VALUE_WIDTH-1]}},
				pend_view[i+1]});
			if (v_ext[i] > -db_ext && v_ext[i] < db_ext) begin
				axes_nxt[i] = '0;
			end else begin
				axes_nxt[i] = $signed(v_ext[i][jfp_pkg::AXIS_W-1:0]);
			end
		end
		if (!start_ok_nxt || byte_s1 != jfp_pkg::CH_NL) begin
			status_nxt = jfp_pkg::ST_MISALIGNED;
		end else if (count_nxt < jfp_pkg::VALUES_FULL) begin
			status_nxt = jfp_pkg::ST_SHORT;
		end else begin
			status_nxt = jfp_pkg::ST_OK;
		end
	end

	// Advance the scanner, restart at the frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			start_ok_q <= 1'b0;
			phase_q    <= jfp_pkg::PH_BRACKET;
			count_q    <= '0;
			acc_q      <= '0;
			neg_q      <= 1'b0;
			seen_q     <= 1'b0;
			stopped_q  <= 1'b0;
		end else if (advance) begin
			if (last) begin
				pos_q      <= '0;
				start_ok_q <= 1'b0;
				phase_q    <= jfp_pkg::PH_BRACKET;
				count_q    <= '0;
				acc_q      <= '0;
				neg_q      <= 1'b0;
				seen_q     <= 1'b0;
				stopped_q  <= 1'b0;
			end else begin
				pos_q      <= pos_q + 1'b1;
				start_ok_q <= start_ok_nxt;
				phase_q    <= phase_nxt;
				count_q    <= count_nxt;
				acc_q      <= acc_nxt;
				neg_q      <= neg_nxt;
				seen_q     <= seen_nxt;
				stopped_q  <= stopped_nxt;
			end
		end
	end

	// Store finished numbers
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			pend_q[count_q] <= fin;
		end
	end

	// Result register and held values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= jfp_pkg::ST_OK;
			buttons_q   <= '0;
			for (int i = 0; i < jfp_pkg::NUM_AXES; i++) begin
				axes_q[i] <= '0;
			end
		end else if (advance && last) begin
			out_valid_q <= 1'b1;
			status_q    <= status_nxt;
			if (status_nxt == jfp_pkg::ST_OK) begin
				buttons_q <= pend_view[0][jfp_pkg::BTN_W-1:0];
				for (int i = 0; i < jfp_pkg::NUM_AXES; i++) begin
					axes_q[i] <= axes_nxt[i];
				end
			end
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Deadband register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= jfp_pkg::DEADBAND_RESET;
		end else if (cfg.valid && cfg.ready) begin
			deadband_q <= cfg.deadband;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.status  = status_q;
	assign res.buttons = buttons_q;
	assign res.left_x  = axes_q[0];
	assign res.left_y  = axes_q[1];
	assign res.right_x = axes_q[2];
	assign res.right_y = axes_q[3];

endmodule

### src/jfp_checker.sv
// Port-level checker of the joystick frame parser and its bind to the top level.
`timescale 1ns / 1ps

module jfp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               rx_ready,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic [1:0]                         status,
	input logic [jfp_pkg::BTN_W-1:0]          buttons,
	input logic signed [jfp_pkg::AXIS_W-1:0]  left_x,
	input logic signed [jfp_pkg::AXIS_W-1:0]  left_y,
	input logic signed [jfp_pkg::AXIS_W-1:0]  right_x,
	input logic signed [jfp_pkg::AXIS_W-1:0]  right_y
);

	logic [jfp_pkg::BTN_W-1:0]          last_btn_q;
	logic signed [jfp_pkg::AXIS_W-1:0]  last_lx_q;
	logic signed [jfp_pkg::AXIS_W-1:0]  last_ly_q;
	logic signed [jfp_pkg::AXIS_W-1:0]  last_rx_q;
	logic signed [jfp_pkg::AXIS_W-1:0]  last_ry_q;

	// Track the values of the last delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_btn_q <= '0;
			last_lx_q  <= '0;
			last_ly_q  <= '0;
			last_rx_q  <= '0;
			last_ry_q  <= '0;
		end else if (res_valid && res_ready) begin
			last_btn_q <= buttons;
			last_lx_q  <= left_x;
			last_ly_q  <= left_y;
			last_rx_q  <= right_x;
			last_ry_q  <= right_y;
		end
	end

	// A stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(buttons) &&
			$stable(left_x) && $stable(left_y) && $stable(right_x) && $stable(right_y))
		else $error("result changed while stalled");

	// A failed frame repeats the last good values
	a_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != jfp_pkg::ST_OK |-> buttons == last_btn_q &&
			left_x == last_lx_q && left_y == last_ly_q &&
			right_x == last_rx_q && right_y == last_ry_q)
		else $error("failed frame changed held values");

	// Input stalls only behind a stalled result
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> res_valid && !res_ready)
		else $error("input stalled without output backpressure");

endmodule

bind joystick_frame_parser jfp_checker u_jfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_ready  (rx.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.status    (res.status),
	.buttons   (res.buttons),
	.left_x    (res.left_x),
	.left_y    (res.left_y),
	.right_x   (res.right_x),
	.right_y   (res.right_y)
);

### verif/joystick_frame_parser_test.sv
// Self-checking testbench of the joystick frame parser: random and directed text frames.
`timescale 1ns / 1ps

module joystick_frame_parser_test;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 5;
	localparam int FRAME_LEN      = jfp_pkg::FRAME_LENGTH_DEF;
	localparam int MAG_LIMIT      = 1 << (jfp_pkg::VALUE_WIDTH_DEF - 1);
	localparam int DEADBAND_MAX   = (1 << jfp_pkg::DB_W) - 1;
	localparam int MAX_WAIT       = 12;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 12;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 4;
	localparam int PHASE_FRAMES   = 10;
	localparam logic [7:0] CH_CLOSE = 8'h3E;

	typedef enum logic [1:0] {
		REQ_BYTE,
		REQ_DEADBAND,
		REQ_DRAIN
	} req_kind_t;

	typedef struct {
		req_kind_t                req_kind;
		logic [jfp_pkg::DB_W-1:0] data;
	} request_t;

	typedef struct {
		jfp_pkg::status_t                  status;
		logic [jfp_pkg::BTN_W-1:0]         buttons;
		logic signed [jfp_pkg::AXIS_W-1:0] left_x;
		logic signed [jfp_pkg::AXIS_W-1:0] left_y;
		logic signed [jfp_pkg::AXIS_W-1:0] right_x;
		logic signed [jfp_pkg::AXIS_W-1:0] right_y;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n;

	jfp_byte_if   rx_ch ();
	jfp_result_if res_ch ();
	jfp_cfg_if    cfg_ch ();

	joystick_frame_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stimulus and expectation stores
	request_t      pending_requests [$];
	frame_result_t expected_frames [$];
	logic [7:0]    frame_buf [FRAME_LEN];

	// Handshakes seen at the last rising edge
	bit rx_fire;
	bit cfg_fire;
	bit res_fire;
	int idle_cycles;

	// Driver and sink pacing
	request_t cur_request;
	bit       req_loaded;
	bit       src_calm;
	bit       sink_calm;
	int       src_wait;
	int       sink_stall;
	int       quiet_cycles;

	// Statistics
	int mismatches;
	int bytes_sent;
	int results_seen;
	int ok_frames;
	int misaligned_frames;
	int short_frames;
	int deadband_writes;

	// Parser copy: frame counter, scanner and held values
	logic [jfp_pkg::DB_W-1:0]          deadband_model;
	int                                frame_pos;
	bit                                frame_start_good;
	jfp_pkg::scan_phase_t              text_phase;
	int                                values_found;
	int                                value_mag;
	bit                                value_neg;
	bit                                value_has_digit;
	bit                                scan_halted;
	int                                pending_values [jfp_pkg::NUM_VALUES];
	logic [jfp_pkg::BTN_W-1:0]         held_buttons;
	logic signed [jfp_pkg::AXIS_W-1:0] held_axes [jfp_pkg::NUM_AXES];

	function automatic void restart_frame_model();
		frame_pos        = 0;
		frame_start_good = 1'b0;
		text_phase       = jfp_pkg::PH_BRACKET;
		values_found     = 0;
		value_mag        = 0;
		value_neg        = 1'b0;
		value_has_digit  = 1'b0;
		scan_halted      = 1'b0;
	endfunction

	function automatic void open_value();
		value_mag       = 0;
		value_neg       = 1'b0;
		value_has_digit = 1'b0;
		text_phase      = jfp_pkg::PH_BEFORE;
	endfunction

	// Advance the parser copy by one byte; return 1 with the frame result at its last byte
	function automatic bit parse_byte(input logic [7:0] b, output frame_result_t r);
		bit is_digit;
		bit is_space;
		int m;
		int v;
		is_digit = (b >= jfp_pkg::CH_ZERO) && (b <= jfp_pkg::CH_NINE);
		is_space = (b == jfp_pkg::CH_SPACE) ||
			((b >= jfp_pkg::CH_TAB) && (b <= jfp_pkg::CH_CR));
		if (frame_pos == 0)
			frame_start_good = (b == jfp_pkg::CH_OPEN);

		// scan the text like a %d list, stopping on the first byte that does not fit
		if (!scan_halted) begin
			case (text_phase)
			jfp_pkg::PH_BRACKET: begin
				if (b == jfp_pkg::CH_OPEN)
					open_value();
				else
					scan_halted = 1'b1;
			end
			jfp_pkg::PH_BEFORE: begin
				if (b == jfp_pkg::CH_PLUS || b == jfp_pkg::CH_MINUS) begin
					value_neg  = (b == jfp_pkg::CH_MINUS);
					text_phase = jfp_pkg::PH_NUMBER;
				end else if (is_digit) begin
					value_mag       = int'(b) - int'(jfp_pkg::CH_ZERO);
					value_has_digit = 1'b1;
					text_phase      = jfp_pkg::PH_NUMBER;
				end else if (!is_space) begin
					scan_halted = 1'b1;
				end
			end
			default: begin
				if (is_digit) begin
					value_mag = value_mag * 10 + int'(b) - int'(jfp_pkg::CH_ZERO);
					if (value_mag > MAG_LIMIT)
						value_mag = MAG_LIMIT;
					value_has_digit = 1'b1;
				end else if (!value_has_digit) begin
					scan_halted = 1'b1;
				end else begin
					// saturate to the signed value range
					m = (value_mag > MAG_LIMIT) ? MAG_LIMIT : value_mag;
					if (value_neg)
						m = -m;
					else if (m > MAG_LIMIT - 1)
						m = MAG_LIMIT - 1;
					if (values_found < jfp_pkg::NUM_VALUES)
						pending_values[values_found] = m;
					values_found++;
					if (values_found >= jfp_pkg::NUM_VALUES || b != jfp_pkg::CH_COMMA)
						scan_halted = 1'b1;
					else
						open_value();
				end
			end
			endcase
		end

		if (frame_pos + 1 < FRAME_LEN) begin
			frame_pos++;
			return 1'b0;
		end

		// last byte: judge the frame and update the held values only when it is good
		if (!frame_start_good || b != jfp_pkg::CH_NL) begin
			r.status = jfp_pkg::ST_MISALIGNED;
		end else if (values_found < jfp_pkg::NUM_VALUES) begin
			r.status = jfp_pkg::ST_SHORT;
		end else begin
			r.status     = jfp_pkg::ST_OK;
			held_buttons = pending_values[0][jfp_pkg::BTN_W-1:0];
			for (int i = 0; i < jfp_pkg::NUM_AXES; i++) begin
				v = pending_values[i + 1];
				if (v > -int'(deadband_model) && v < int'(deadband_model))
					v = 0;
				held_axes[i] = v[jfp_pkg::AXIS_W-1:0];
			end
		end
		r.buttons = held_buttons;
		r.left_x  = held_axes[0];
		r.left_y  = held_axes[1];
		r.right_x = held_axes[2];
		r.right_y = held_axes[3];
		restart_frame_model();
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [jfp_pkg::AXIS_W-1:0] got,
		logic [jfp_pkg::AXIS_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h want %h",
				results_seen, name, got, want));
	endtask

	// Stimulus building
	task automatic push_request(req_kind_t req_kind, logic [jfp_pkg::DB_W-1:0] data);
		request_t req;
		req.req_kind = req_kind;
		req.data     = data;
		pending_requests.push_back(req);
	endtask

	task automatic load_frame(string body, logic [7:0] filler);
		for (int i = 0; i < FRAME_LEN; i++)
			frame_buf[i] = (i < body.len() && i < FRAME_LEN - 1) ? body[i] : filler;
		frame_buf[FRAME_LEN - 1] = jfp_pkg::CH_NL;
	endtask

	task automatic push_frame();
		for (int i = 0; i < FRAME_LEN; i++)
			push_request(REQ_BYTE, jfp_pkg::DB_W'(frame_buf[i]));
	endtask

	// One number of the list, mostly short, sometimes past the value range or near the deadband
	function automatic string number_text(bit for_button, int db);
		int    mag;
		string sign_txt;
		string lead;
		case ($urandom_range(0, for_button ? 5 : 7))
		0, 1: mag = $urandom_range(0, 9);
		2: mag = $urandom_range(10, 99);
		3: mag = $urandom_range(100, 999);
		4: mag = $urandom_range(1000, MAG_LIMIT - 1);
		5: mag = $urandom_range(MAG_LIMIT, 99999);
		default: mag = ((db > 0) ? db - 1 : 0) + $urandom_range(0, 2);
		endcase
		sign_txt = "";
		case ($urandom_range(0, 5))
		0, 1: sign_txt = "-";
		2: sign_txt = "+";
		default: ;
		endcase
		lead = "";
		if ($urandom_range(0, 7) == 0)
			lead = $sformatf("%c", $urandom_range(0, 1) ? jfp_pkg::CH_SPACE : jfp_pkg::CH_TAB);
		return {lead, sign_txt, $sformatf("%0d", mag)};
	endfunction

	function automatic string good_body(int db);
		return {"<", number_text(1'b1, db), ",", number_text(1'b0, db), ",",
			number_text(1'b0, db), ",", number_text(1'b0, db), ",", number_text(1'b0, db)};
	endfunction

	function automatic string short_body(int db);
		string s;
		int    k;
		s = "<";
		k = $urandom_range(0, jfp_pkg::NUM_VALUES - 1);
		for (int i = 0; i < k; i++) begin
			if (i > 0)
				s = {s, ","};
			s = {s, number_text(i == 0, db)};
		end
		return s;
	endfunction

	// Mostly well-formed frames with random content, the rest noise and broken frames
	task automatic queue_random_frame(int db);
		logic [7:0] filler;
		logic [7:0] odd_chars [4];
		odd_chars = '{8'h00, jfp_pkg::CH_PLUS, jfp_pkg::CH_MINUS, jfp_pkg::CH_COMMA};
		case ($urandom_range(0, 2))
		0: filler = CH_CLOSE;
		1: filler = jfp_pkg::CH_SPACE;
		default: filler = 8'($urandom_range(0, 255));
		endcase
		load_frame(good_body(db), filler);
		case ($urandom_range(0, 19))
		14: begin
			for (int i = 0; i < FRAME_LEN; i++)
				frame_buf[i] = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 1)) begin
				frame_buf[0]             = jfp_pkg::CH_OPEN;
				frame_buf[FRAME_LEN - 1] = jfp_pkg::CH_NL;
			end
		end
		15: begin
			frame_buf[0] = 8'($urandom_range(0, 255));
			if (frame_buf[0] == jfp_pkg::CH_OPEN)
				frame_buf[0] = jfp_pkg::CH_OPEN ^ 8'h01;
		end
		16: begin
			frame_buf[FRAME_LEN - 1] = 8'($urandom_range(0, 255));
			if (frame_buf[FRAME_LEN - 1] == jfp_pkg::CH_NL)
				frame_buf[FRAME_LEN - 1] = jfp_pkg::CH_NL ^ 8'h80;
		end
		17: frame_buf[$urandom_range(1, FRAME_LEN - 2)] = 8'($urandom_range(0, 255));
		18: load_frame(short_body(db), filler);
		19: frame_buf[$urandom_range(1, FRAME_LEN - 2)] = odd_chars[$urandom_range(0, 3)];
		default: ;
		endcase
		push_frame();
	endtask

	// Sample handshakes, check results and predict at each rising edge
	always @(posedge clk) begin
		frame_result_t want;
		frame_result_t pred;
		rx_fire  = arst_n && rx_ch.valid && rx_ch.ready;
		cfg_fire = arst_n && cfg_ch.valid && cfg_ch.ready;
		res_fire = arst_n && res_ch.valid && res_ch.ready;
		if (rx_fire || cfg_fire || res_fire)
			idle_cycles = 0;
		else
			idle_cycles++;

		// compare an accepted result with the oldest expectation
		if (res_fire) begin
			results_seen++;
			if (expected_frames.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = expected_frames.pop_front();
				check_field("status", jfp_pkg::AXIS_W'(res_ch.status),
					jfp_pkg::AXIS_W'(want.status));
				check_field("buttons", jfp_pkg::AXIS_W'(res_ch.buttons),
					jfp_pkg::AXIS_W'(want.buttons));
				check_field("left_x", res_ch.left_x, want.left_x);
				check_field("left_y", res_ch.left_y, want.left_y);
				check_field("right_x", res_ch.right_x, want.right_x);
				check_field("right_y", res_ch.right_y, want.right_y);
				case (want.status)
				jfp_pkg::ST_OK: ok_frames++;
				jfp_pkg::ST_MISALIGNED: misaligned_frames++;
				default: short_frames++;
				endcase
			end
		end

		if (cfg_fire) begin
			deadband_model = cfg_ch.deadband;
			deadband_writes++;
		end

		if (rx_fire) begin
			bytes_sent++;
			if (parse_byte(rx_ch.rx_byte, pred))
				expected_frames.push_back(pred);
		end
	end

	// Present requests from the pending queue at falling edges
	always @(negedge clk) begin
		logic next_rx_valid;
		logic next_cfg_valid;
		if (arst_n) begin
			next_rx_valid  = rx_ch.valid && !rx_fire;
			next_cfg_valid = cfg_ch.valid && !cfg_fire;
			if (expected_frames.size() == 0 && !rx_ch.valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;

			if (!next_rx_valid && !next_cfg_valid) begin
				// load the next request and draw its gap
				if (!req_loaded && pending_requests.size() > 0) begin
					cur_request = pending_requests.pop_front();
					req_loaded  = 1'b1;
					if ($urandom_range(0, 29) == 0)
						src_calm = !src_calm;
					src_wait = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
				end
				if (req_loaded) begin
					if (src_wait > 0) begin
						src_wait--;
					end else begin
						case (cur_request.req_kind)
						REQ_BYTE: begin
							next_rx_valid = 1'b1;
							rx_ch.rx_byte <= cur_request.data[7:0];
							req_loaded    = 1'b0;
						end
						REQ_DEADBAND: begin
							// write the register only once the parser has gone idle
							if (quiet_cycles >= SETTLE_CYCLES) begin
								next_cfg_valid   = 1'b1;
								cfg_ch.deadband <= cur_request.data;
								req_loaded       = 1'b0;
							end
						end
						default: begin
							// hold off until every expected result is in
							if (expected_frames.size() == 0)
								req_loaded = 1'b0;
						end
						endcase
					end
				end
			end
			rx_ch.valid  <= next_rx_valid;
			cfg_ch.valid <= next_cfg_valid;
		end
	end

	// Stall the result channel for a random number of cycles after each accepted result
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_fire) begin
				if ($urandom_range(0, 29) == 0)
					sink_calm = !sink_calm;
				sink_stall = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (sink_stall > 0) begin
				sink_stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// End the run when nothing has been accepted for too long
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("joystick_frame_parser verification failed");
		$finish;
	end

	initial begin
		int phase_db;
		arst_n          = 1'b0;
		rx_ch.valid     = 1'b0;
		rx_ch.rx_byte   = 8'h00;
		cfg_ch.valid    = 1'b0;
		cfg_ch.deadband = '0;
		res_ch.ready    = 1'b0;

		// parser copy after reset
		deadband_model = jfp_pkg::DEADBAND_RESET;
		restart_frame_model();
		for (int i = 0; i < jfp_pkg::NUM_VALUES; i++)
			pending_values[i] = 0;
		held_buttons = '0;
		for (int i = 0; i < jfp_pkg::NUM_AXES; i++)
			held_axes[i] = '0;

		// directed frames at the reset deadband
		load_frame("<0,0,0,0,0", CH_CLOSE);
		push_frame();
		load_frame("<255,32767,-32768,19,-19", CH_CLOSE);
		push_frame();
		load_frame("<256,20,-20,21,-21", jfp_pkg::CH_SPACE);
		push_frame();
		load_frame("<99999,40000,-99999,1,2", CH_CLOSE);
		push_frame();
		load_frame($sformatf("<%c+7,%c-30,%c45,%c+50,-60", jfp_pkg::CH_SPACE, jfp_pkg::CH_TAB,
			8'h0B, jfp_pkg::CH_CR), CH_CLOSE);
		push_frame();
		// misaligned start, then misaligned end
		load_frame("x1,2,3,4,5", CH_CLOSE);
		push_frame();
		load_frame("<1,2,3,4,5", CH_CLOSE);
		frame_buf[FRAME_LEN - 1] = CH_CLOSE;
		push_frame();
		// too few numbers, bare sign, zero byte, trailing text, space before comma
		load_frame("<1,2,3", CH_CLOSE);
		push_frame();
		load_frame("<1,-,3,4,5", CH_CLOSE);
		push_frame();
		load_frame("<1,2,3,4,5", CH_CLOSE);
		frame_buf[4] = 8'h00;
		push_frame();
		load_frame("<1,100,200,300,400>junk", CH_CLOSE);
		push_frame();
		load_frame("<1 ,2,3,4,5", CH_CLOSE);
		push_frame();
		// zero deadband passes every axis
		push_request(REQ_DEADBAND, '0);
		load_frame("<5,6,-1,1,-32768", CH_CLOSE);
		push_frame();
		// widest deadband
		push_request(REQ_DEADBAND, jfp_pkg::DB_W'(DEADBAND_MAX));
		load_frame("<1,32767,-32767,-32768,100", CH_CLOSE);
		push_frame();
		load_frame("<-1,32766,-32766,0,+32767", CH_CLOSE);
		push_frame();

		// random phases, each at its own deadband
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
			0: phase_db = $urandom_range(1, 400);
			1: phase_db = DEADBAND_MAX;
			2: phase_db = $urandom_range(0, DEADBAND_MAX);
			default: phase_db = jfp_pkg::DEADBAND_RESET;
			endcase
			push_request(REQ_DEADBAND, jfp_pkg::DB_W'(phase_db));
			if (p == 2)
				push_request(REQ_DRAIN, '0);
			for (int f = 0; f < PHASE_FRAMES; f++) begin
				if ($urandom_range(0, 9) == 0)
					push_request(REQ_DRAIN, '0);
				queue_random_frame(phase_db);
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for every request to go out and every result to come back
		while (pending_requests.size() > 0 || req_loaded || rx_ch.valid || cfg_ch.valid
			|| expected_frames.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d bytes; checked %0d frames: %0d parsed, %0d misaligned, %0d short.",
			bytes_sent, results_seen, ok_frames, misaligned_frames, short_frames);
		$display("Deadband written %0d times; %0d mismatches.", deadband_writes, mismatches);
		if (mismatches == 0)
			$display("joystick_frame_parser verification clean");
		else
			$display("joystick_frame_parser verification failed");
		$finish;
	end

endmodule

### joystick_frame_parser.f
src/jfp_pkg.sv
src/jfp_ifs.sv
src/joystick_frame_parser.sv
src/jfp_checker.sv
verif/joystick_frame_parser_test.sv
